// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_DIGEST  = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// command handed from the front part to the compression engine
	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
	} cmd_t;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueueAw    = $clog2(QueueDepth);

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [7:0]  PadByte = 8'h80;

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) k = 32'h5A827999;
		else if (r < 7'd40) k = 32'h6ED9EBA1;
		else if (r < 7'd60) k = 32'h8F1BBCDC;
		else k = 32'hCA62C1D6;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) f = (b & c) | (~b & d);
		else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

endpackage

// ===== rtl/core/sha1_front.sv =====
module sha1_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic [1:0]          s_tuser,
	output logic                q_valid,
	input  logic                q_ready,
	output sha1_pkg::cmd_t      q_cmd
);
	import sha1_pkg::*;

	cmd_t                 mem_q [QueueDepth];
	logic [QueueAw-1:0]   wr_q, rd_q;
	logic [QueueAw:0]     cnt_q;
	logic                 push, pop;
	op_t                  op_in;

	assign op_in    = op_t'(s_tuser);
	assign s_tready = (cnt_q != (QueueAw+1)'(QueueDepth));
	assign push     = s_tvalid && s_tready && op_in != OP_NONE;
	assign q_valid  = cnt_q != '0;
	assign pop      = q_valid && q_ready;
	assign q_cmd    = mem_q[rd_q];

	// classify beats and queue the useful ones
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{op: op_in, data_byte: s_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
		end
	end
endmodule

// ===== rtl/core/sha1_back.sv =====
module sha1_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  sha1_pkg::cmd_t q_cmd,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [39:0]    m_tdata,
	output logic           m_tuser,
	output logic           m_tlast
);
	import sha1_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
	} state_t;

	state_t        state_q;
	logic [7:0]    buf_q [64];
	logic [5:0]    fill_q;
	logic [63:0]   len_q;
	logic          ovf_q;
	logic [31:0]   h_q [5];      // chaining words
	logic [31:0]   t_q [5];      // working hash for the current compression
	logic [31:0]   a_q, b_q, c_q, d_q, e_q;
	logic [31:0]   w_q [16];
	logic [6:0]    rnd_q;
	logic [5:0]    ld_q;         // byte position while loading the schedule
	logic [5:0]    pos_b;        // position of the byte arriving from the buffer
	logic          dig_q;        // compression belongs to a digest
	logic          second_q;     // digest needs a second block
	logic          pass_q;       // current digest block number
	logic [2:0]    idx_q;
	logic [7:0]    ld_byte;
	logic [7:0]    rd_byte_q;
	logic [31:0]   wnew, tsum, wcur;

	assign q_ready = (state_q == ST_IDLE);
	assign pos_b   = ld_q - 6'd1;

	// byte source for the schedule: stored data, pad, zeros or length
	always_comb begin
		ld_byte = 8'h00;
		if (!dig_q) begin
			ld_byte = rd_byte_q;
		end else if (!pass_q) begin
			if (pos_b < fill_q) ld_byte = rd_byte_q;
			else if (pos_b == fill_q) ld_byte = PadByte;
			else if (!second_q && pos_b >= 6'd56)
				ld_byte = len_q[8'(7 - (pos_b - 6'd56)) * 8 +: 8];
		end else if (pos_b >= 6'd56) begin
			ld_byte = len_q[8'(7 - (pos_b - 6'd56)) * 8 +: 8];
		end
	end

	assign wcur = w_q[0];
	assign wnew = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]} << 1
		| (w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]) >> 31;
	assign tsum = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
		+ wcur + round_k(rnd_q);

	// buffer memory, registered read
	always_ff @(posedge clk) begin
		rd_byte_q <= buf_q[ld_q];
		if (state_q == ST_IDLE && q_valid && q_cmd.op == OP_APPEND && !ovf_q)
			buf_q[fill_q] <= q_cmd.data_byte;
	end

	// schedule window: bytewise shift while loading, word shift per round
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && ld_q != 6'd0 || state_q == ST_LOAD && rnd_q[0]) begin
			for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], ld_byte};
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	// sequencer: load 64 bytes, run 80 rounds, fold, then emit the digest words after a digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			h_q      <= '{H0, H1, H2, H3, H4};
			rnd_q    <= '0;
			ld_q     <= '0;
			dig_q    <= 1'b0;
			second_q <= 1'b0;
			pass_q   <= 1'b0;
			idx_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.op)
							OP_APPEND: begin
								if (!ovf_q) begin
									fill_q <= fill_q + 6'd1;
									len_q  <= len_q + 64'd8;
									if (len_q == 64'hFFFF_FFFF_FFFF_FFF8) ovf_q <= 1'b1;
									if (fill_q == 6'd63) begin
										dig_q   <= 1'b0;
										ld_q    <= '0;
										rnd_q   <= '0;
										t_q     <= h_q;
										state_q <= ST_LOAD;
									end
								end
							end
							OP_DIGEST: begin
								dig_q    <= 1'b1;
								second_q <= fill_q >= 6'd56;
								pass_q   <= 1'b0;
								ld_q     <= '0;
								rnd_q    <= '0;
								t_q      <= h_q;
								state_q  <= ST_LOAD;
							end
							OP_RESTART: begin
								fill_q <= '0;
								len_q  <= '0;
								ovf_q  <= 1'b0;
								h_q    <= '{H0, H1, H2, H3, H4};
							end
							default: ;
						endcase
					end
				end
				ST_LOAD: begin
					// rnd_q[0] marks that the first read is in flight
					if (!rnd_q[0]) begin
						rnd_q <= 7'd1;
						ld_q  <= 6'd1;
					end else begin
						ld_q <= ld_q + 6'd1;
						if (ld_q == 6'd0) begin
							rnd_q   <= '0;
							a_q     <= t_q[0];
							b_q     <= t_q[1];
							c_q     <= t_q[2];
							d_q     <= t_q[3];
							e_q     <= t_q[4];
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					e_q   <= d_q;
					d_q   <= c_q;
					c_q   <= {b_q[1:0], b_q[31:2]};
					b_q   <= a_q;
					a_q   <= tsum;
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd79) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					t_q[0] <= t_q[0] + a_q;
					t_q[1] <= t_q[1] + b_q;
					t_q[2] <= t_q[2] + c_q;
					t_q[3] <= t_q[3] + d_q;
					t_q[4] <= t_q[4] + e_q;
					rnd_q  <= '0;
					ld_q   <= '0;
					if (!dig_q) begin
						h_q[0] <= t_q[0] + a_q;
						h_q[1] <= t_q[1] + b_q;
						h_q[2] <= t_q[2] + c_q;
						h_q[3] <= t_q[3] + d_q;
						h_q[4] <= t_q[4] + e_q;
						fill_q <= '0;
						state_q <= ST_IDLE;
					end else if (second_q && !pass_q) begin
						pass_q  <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						idx_q    <= '0;
						m_tvalid <= 1'b1;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd4) begin
							m_tvalid <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {5'b0, idx_q, t_q[idx_q]};
	assign m_tuser = ovf_q;
	assign m_tlast = (idx_q == 3'd4);
endmodule

// ===== rtl/core/sha1_byte_stream_hasher_core.sv =====
// sha-1 over a byte stream, one 80-round compression per 64-byte block
// append: one byte per cycle while the engine is idle, plus a compression at each full block
// (schedule load, 80 rounds, fold); the engine takes no byte while it compresses a block
// digest: one or two block compressions, then five output beats
// a 4-deep command queue lets input beats continue during compression
// arst_n clears the control state and loads the sha-1 initial hash
module sha1_byte_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32]
	output logic        m_tuser,  // corrupted
	output logic        m_tlast   // last_word
);
	import sha1_pkg::*;

	cmd_t q_cmd;
	logic q_valid, q_ready;

	sha1_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.q_valid, .q_ready, .q_cmd
	);

	sha1_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);
endmodule
